>>> rtl/jaos_pkg.sv
// Shared types and constants for the JSON array object splitter.
// No dependencies; every other file imports this package.
package jaos_pkg;

  // Widths and limits
  localparam int OFFSET_BITS = 16;
  localparam int POS_W       = OFFSET_BITS + 1;
  localparam int SPAN_W      = OFFSET_BITS + 1;
  localparam int MAX_NEST    = 255;
  localparam int DEPTH_W     = $clog2(MAX_NEST + 1);

  // Characters of interest
  localparam logic [7:0] CH_LBRACK    = 8'h5B; // '['
  localparam logic [7:0] CH_RBRACK    = 8'h5D; // ']'
  localparam logic [7:0] CH_LBRACE    = 8'h7B; // '{'
  localparam logic [7:0] CH_RBRACE    = 8'h7D; // '}'
  localparam logic [7:0] CH_COMMA     = 8'h2C; // ','
  localparam logic [7:0] CH_BACKSLASH = 8'h5C; // '\'
  localparam logic [7:0] CH_QUOTE     = 8'h22; // '"'
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_START     = 3'd1,
    EV_END       = 3'd2,
    EV_ARRAY_END = 3'd3,
    EV_ERROR     = 3'd4
  } event_kind_t;

  typedef struct packed {
    event_kind_t              event_kind;
    logic [OFFSET_BITS-1:0]   byte_offset;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [SPAN_W-1:0]        span_length;
  } scan_result_t;

endpackage

>>> rtl/jaos_if.sv
// Valid/ready stream interfaces for the splitter's byte input and event output.
// Depends on jaos_pkg for field widths and the event code type.
interface jaos_in_if import jaos_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface jaos_out_if import jaos_pkg::*; ();
  logic                   valid;
  logic                   ready;
  event_kind_t            event_kind;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [SPAN_W-1:0]      span_length;

  modport source (output valid, output event_kind, output byte_offset,
                  output start_offset, output span_length, input ready);
  modport sink   (input valid, input event_kind, input byte_offset,
                  input start_offset, input span_length, output ready);
endinterface

>>> rtl/jaos_scan.sv
// Per-byte scanner: phase, nesting, string and position state, plus the
// combinational event for the current byte. Depends on jaos_pkg.
module jaos_scan import jaos_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   text_byte,
  input  logic         final_byte,
  output scan_result_t result
);

  typedef enum logic [2:0] {
    PH_OPEN, PH_FIRST, PH_AFTER_OBJ, PH_AFTER_COMMA, PH_IN_OBJ, PH_DONE, PH_ERROR
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_cur;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic                   in_str_r, in_str_nxt;
  logic                   esc_r, esc_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] origin_r, origin_nxt;

  logic                   blank;
  logic                   pos_ovf;
  event_kind_t            ev;
  logic [OFFSET_BITS-1:0] start;
  logic [SPAN_W-1:0]      span;

  assign blank   = (text_byte == CH_SPACE) || (text_byte inside {[CH_TAB:CH_CR]});
  assign pos_ovf = pos_r[POS_W-1];

  // Work out the next state and the event for this byte
  always_comb begin
    phase_nxt  = phase_r;
    depth_nxt  = depth_r;
    in_str_nxt = in_str_r;
    esc_nxt    = esc_r;
    origin_nxt = origin_r;
    ev         = EV_NONE;
    start      = '0;
    span       = '0;

    // Flag a byte whose offset no longer fits
    phase_cur = phase_r;
    if (phase_r != PH_DONE && phase_r != PH_ERROR && pos_ovf) begin
      phase_cur = PH_ERROR;
    end
    phase_nxt = phase_cur;

    case (phase_cur)
      PH_OPEN: begin
        if (text_byte == CH_LBRACK) begin
          phase_nxt = PH_FIRST;
        end else if (!blank) begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_FIRST, PH_AFTER_OBJ, PH_AFTER_COMMA: begin
        if (blank) begin
          phase_nxt = phase_cur;
        end else if (text_byte == CH_RBRACK) begin
          phase_nxt = PH_DONE;
          ev        = EV_ARRAY_END;
        end else if (text_byte == CH_LBRACE) begin
          phase_nxt  = PH_IN_OBJ;
          depth_nxt  = DEPTH_W'(1);
          in_str_nxt = 1'b0;
          esc_nxt    = 1'b0;
          origin_nxt = pos_r[OFFSET_BITS-1:0];
          ev         = EV_START;
          start      = pos_r[OFFSET_BITS-1:0];
        end else if (text_byte == CH_COMMA && phase_cur == PH_AFTER_OBJ) begin
          phase_nxt = PH_AFTER_COMMA;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_IN_OBJ: begin
        start = origin_r;
        if (in_str_r) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (text_byte == CH_BACKSLASH) begin
            esc_nxt = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            in_str_nxt = 1'b0;
          end
        end else if (text_byte == CH_QUOTE) begin
          in_str_nxt = 1'b1;
        end else if (text_byte == CH_LBRACE || text_byte == CH_LBRACK) begin
          if (depth_r >= DEPTH_W'(MAX_NEST)) begin
            phase_nxt = PH_ERROR;
          end else begin
            depth_nxt = depth_r + DEPTH_W'(1);
          end
        end else if (text_byte == CH_RBRACE || text_byte == CH_RBRACK) begin
          if (depth_r == '0) begin
            phase_nxt = PH_ERROR;
          end else begin
            depth_nxt = depth_r - DEPTH_W'(1);
            if (depth_r == DEPTH_W'(1)) begin
              ev        = EV_END;
              span      = {1'b0, pos_r[OFFSET_BITS-1:0]} - {1'b0, origin_r}
                          + SPAN_W'(1);
              phase_nxt = PH_AFTER_OBJ;
            end
          end
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    // A payload that ends before ']' is an error
    if (final_byte && phase_nxt != PH_DONE) begin
      phase_nxt = PH_ERROR;
    end

    if (phase_nxt == PH_ERROR) begin
      ev    = EV_ERROR;
      start = '0;
      span  = '0;
    end

    // Advance the position, saturating one past the last offset
    pos_nxt = pos_r;
    if (!pos_ovf) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign result.event_kind   = ev;
  assign result.byte_offset  = pos_r[OFFSET_BITS-1:0];
  assign result.start_offset = start;
  assign result.span_length  = span;

  // Hold state; return to reset after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && final_byte)) begin
      phase_r  <= PH_OPEN;
      depth_r  <= '0;
      in_str_r <= 1'b0;
      esc_r    <= 1'b0;
      pos_r    <= '0;
      origin_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      depth_r  <= depth_nxt;
      in_str_r <= in_str_nxt;
      esc_r    <= esc_nxt;
      pos_r    <= pos_nxt;
      origin_r <= origin_nxt;
    end
  end

endmodule

>>> rtl/json_array_object_splitter.sv
// Top level of the JSON array object splitter: byte input, event output register.
// Depends on jaos_pkg, jaos_in_if / jaos_out_if and jaos_scan.
//
// Takes one byte of JSON array text per word and returns exactly one event word
// for each byte: none, object start, object end (with start offset and length),
// array end, or error. Errors are sticky until the byte marked final_byte, after
// which the scanner is back in its reset state. Throughput is one byte per clock
// while the sink keeps up; a result appears in the cycle after its byte is taken,
// from a single output register that refills in the same cycle it is drained, so
// in_ready drops only while that register is full and the sink is stalling.
module json_array_object_splitter import jaos_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  jaos_in_if.sink     in_stream,
  jaos_out_if.source  out_stream
);

  logic         step_en;
  logic         out_valid_r;
  scan_result_t scan_res;
  scan_result_t out_data_r;

  // Take a byte whenever the output register is free or being drained
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign step_en         = in_stream.valid && in_stream.ready;

  jaos_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .text_byte  (in_stream.text_byte),
    .final_byte (in_stream.final_byte),
    .result     (scan_res)
  );

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= scan_res;
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.event_kind   = out_data_r.event_kind;
  assign out_stream.byte_offset  = out_data_r.byte_offset;
  assign out_stream.start_offset = out_data_r.start_offset;
  assign out_stream.span_length  = out_data_r.span_length;

endmodule
